FILE: rtl/core/segment_intersection_unit_assert.svh
// Assertion macros for the segment intersection unit.
`ifndef SEGMENT_INTERSECTION_UNIT_ASSERT_SVH
`define SEGMENT_INTERSECTION_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SEGI_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define SEGI_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/segi_pkg.sv
// Shared types for the segment intersection pipeline.
package segi_pkg;

	typedef struct packed {
		logic hit;
		logic neg;
	} segi_side_t;

endpackage

FILE: rtl/core/segment_intersection_unit.sv
// Segment intersection: pipelined crossing test and crossing point of two 2D segments.
// Throughput: one beat per cycle while the skid entry is empty; four front stages, then one quotient bit per stage.
// A two-entry output register and skid buffer keep s_tready registered-only.
// Reset clears all valid bits and the output and skid flags; data registers hold no reset.
`include "segment_intersection_unit_assert.svh"

module segment_intersection_unit #(
	parameter int COORD_WIDTH = 16,
	localparam int IN_W  = ((8 * COORD_WIDTH + 7) / 8) * 8,
	localparam int OUT_W = ((2 * COORD_WIDTH + 7) / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	// first_start_x, first_start_y, first_end_x, first_end_y,
	// second_start_x, second_start_y, second_end_x, second_end_y
	input  logic [IN_W-1:0]  s_tdata,
	output logic             m_tvalid,
	input  logic             m_tready,
	// cross_x, cross_y, zero pad
	output logic [OUT_W-1:0] m_tdata,
	// hit
	output logic [0:0]       m_tuser
);
	import segi_pkg::*;

	localparam int W  = COORD_WIDTH;
	localparam int CW = 2 * W + 2;
	localparam int UW = 2 * W + 1;

	logic en;
	logic in_fire;
	logic out_fire;

	logic signed [W-1:0] ax, ay, bx, by, cx, cy, dx, dy;

	logic                v_s1, v_s2, v_s3, v_s4;
	logic signed [W:0]   rx_s1, ry_s1, sx_s1, sy_s1, mx_s1, my_s1;
	logic signed [W-1:0] ax_s1, ay_s1;

	logic signed [CW-1:0] p_rxsy_s2, p_rysx_s2, p_mxsy_s2, p_mysx_s2, p_mxry_s2, p_myrx_s2;
	logic signed [W:0]    rx_s2, ry_s2;
	logic signed [W-1:0]  ax_s2, ay_s2;

	logic signed [CW-1:0] rs_s3, tn_s3, un_s3;
	logic signed [W:0]    rx_s3, ry_s3;
	logic signed [W-1:0]  ax_s3, ay_s3;

	logic                hit_s4, negx_s4, negy_s4;
	logic [UW-1:0]       rs_s4, tn_s4;
	logic [W-1:0]        rmx_s4, rmy_s4;
	logic signed [W-1:0] ax_s4, ay_s4;

	logic                 rs_pos, rs_neg, hit_c;
	logic signed [CW-1:0] rs_abs, tn_abs;
	logic signed [W:0]    rx_abs, ry_abs;

	logic          vld_x, vld_y;
	logic          hit_x, hit_y;
	logic [W-1:0]  pt_x, pt_y;

	logic          skid_valid_q;
	logic          hit_q, skid_hit_q;
	logic [W-1:0]  out_x_q, out_y_q, skid_x_q, skid_y_q;

	assign en       = !skid_valid_q;
	assign s_tready = en;
	assign in_fire  = s_tvalid && s_tready;
	assign out_fire = m_tvalid && m_tready;

	assign ax = $signed(s_tdata[0*W +: W]);
	assign ay = $signed(s_tdata[1*W +: W]);
	assign bx = $signed(s_tdata[2*W +: W]);
	assign by = $signed(s_tdata[3*W +: W]);
	assign cx = $signed(s_tdata[4*W +: W]);
	assign cy = $signed(s_tdata[5*W +: W]);
	assign dx = $signed(s_tdata[6*W +: W]);
	assign dy = $signed(s_tdata[7*W +: W]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_fire;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_comb begin
		rs_pos = !rs_s3[CW-1] && (rs_s3 != '0);
		rs_neg = rs_s3[CW-1];
		hit_c  = (rs_pos && !tn_s3[CW-1] && (tn_s3 <= rs_s3)
				&& !un_s3[CW-1] && (un_s3 <= rs_s3))
			|| (rs_neg && (tn_s3 <= 0) && (tn_s3 >= rs_s3)
				&& (un_s3 <= 0) && (un_s3 >= rs_s3));
		rs_abs = rs_neg ? -rs_s3 : rs_s3;
		tn_abs = rs_neg ? -tn_s3 : tn_s3;
		rx_abs = rx_s3[W] ? -rx_s3 : rx_s3;
		ry_abs = ry_s3[W] ? -ry_s3 : ry_s3;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rx_s1 <= {bx[W-1], bx} - {ax[W-1], ax};
			ry_s1 <= {by[W-1], by} - {ay[W-1], ay};
			sx_s1 <= {dx[W-1], dx} - {cx[W-1], cx};
			sy_s1 <= {dy[W-1], dy} - {cy[W-1], cy};
			mx_s1 <= {cx[W-1], cx} - {ax[W-1], ax};
			my_s1 <= {cy[W-1], cy} - {ay[W-1], ay};
			ax_s1 <= ax;
			ay_s1 <= ay;

			p_rxsy_s2 <= rx_s1 * sy_s1;
			p_rysx_s2 <= ry_s1 * sx_s1;
			p_mxsy_s2 <= mx_s1 * sy_s1;
			p_mysx_s2 <= my_s1 * sx_s1;
			p_mxry_s2 <= mx_s1 * ry_s1;
			p_myrx_s2 <= my_s1 * rx_s1;
			rx_s2     <= rx_s1;
			ry_s2     <= ry_s1;
			ax_s2     <= ax_s1;
			ay_s2     <= ay_s1;

			rs_s3 <= p_rxsy_s2 - p_rysx_s2;
			tn_s3 <= p_mxsy_s2 - p_mysx_s2;
			un_s3 <= p_mxry_s2 - p_myrx_s2;
			rx_s3 <= rx_s2;
			ry_s3 <= ry_s2;
			ax_s3 <= ax_s2;
			ay_s3 <= ay_s2;

			hit_s4  <= hit_c;
			rs_s4   <= rs_abs[UW-1:0];
			tn_s4   <= tn_abs[UW-1:0];
			rmx_s4  <= rx_abs[W-1:0];
			rmy_s4  <= ry_abs[W-1:0];
			negx_s4 <= rx_s3[W];
			negy_s4 <= ry_s3[W];
			ax_s4   <= ax_s3;
			ay_s4   <= ay_s3;
		end
	end

	segi_div #(
		.W (W)
	) u_div_x (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s4),
		.in_side   (segi_side_t'{hit: hit_s4, neg: negx_s4}),
		.in_base   (ax_s4),
		.in_rmag   (rmx_s4),
		.in_tn     (tn_s4),
		.in_rs     (rs_s4),
		.out_valid (vld_x),
		.out_hit   (hit_x),
		.out_point (pt_x)
	);

	segi_div #(
		.W (W)
	) u_div_y (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s4),
		.in_side   (segi_side_t'{hit: hit_s4, neg: negy_s4}),
		.in_base   (ay_s4),
		.in_rmag   (rmy_s4),
		.in_tn     (tn_s4),
		.in_rs     (rs_s4),
		.out_valid (vld_y),
		.out_hit   (hit_y),
		.out_point (pt_y)
	);

	// hold a finished beat in the skid entry while the output register waits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid     <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (out_fire) begin
				skid_valid_q <= 1'b0;
			end
		end else if (vld_x) begin
			if (!m_tvalid || out_fire) begin
				m_tvalid <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (out_fire) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_fire) begin
				hit_q   <= skid_hit_q;
				out_x_q <= skid_x_q;
				out_y_q <= skid_y_q;
			end
		end else if (vld_x) begin
			if (!m_tvalid || out_fire) begin
				hit_q   <= hit_x;
				out_x_q <= pt_x;
				out_y_q <= pt_y;
			end else begin
				skid_hit_q <= hit_x;
				skid_x_q   <= pt_x;
				skid_y_q   <= pt_y;
			end
		end
	end

	assign m_tdata = OUT_W'({out_y_q, out_x_q});
	assign m_tuser = hit_q;

	`SEGI_ASSERT_NOW(a_lane_sync, 1'b1, vld_x == vld_y, "axis lanes out of step")
	`SEGI_ASSERT_NOW(a_lane_hit, vld_x, hit_x == hit_y, "axis lanes disagree on hit")
	`SEGI_ASSERT_NOW(a_skid_needs_out, skid_valid_q, m_tvalid, "skid entry full without output")
	`SEGI_ASSERT_NOW(a_miss_zero, m_tvalid && !m_tuser[0], m_tdata == '0, "miss with nonzero point")
	`SEGI_ASSERT_NEXT(a_skid_hold, skid_valid_q && !m_tready, skid_valid_q, "skid entry lost")

endmodule

FILE: rtl/core/segi_div.sv
// One-axis lane: pipelined trunc(tn * |r| / rs) and crossing coordinate, one bit per stage.
module segi_div #(
	parameter int W = 16,
	localparam int UW = 2 * W + 1
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   in_valid,
	input  segi_pkg::segi_side_t   in_side,
	input  logic signed [W-1:0]    in_base,
	input  logic [W-1:0]           in_rmag,
	input  logic [UW-1:0]          in_tn,
	input  logic [UW-1:0]          in_rs,
	output logic                   out_valid,
	output logic                   out_hit,
	output logic [W-1:0]           out_point
);
	import segi_pkg::*;

	logic               valid_s [0:W];
	segi_side_t         side_s  [0:W];
	logic signed [W-1:0] base_s [0:W];
	logic [W-1:0]       rmag_s  [0:W];
	logic [UW-1:0]      tn_s    [0:W];
	logic [UW-1:0]      rs_s    [0:W];
	logic [UW-1:0]      rem_s   [0:W];
	logic [W-1:0]       q_s     [0:W];

	logic signed [W:0]  offset;
	logic signed [W:0]  sum;

	assign valid_s[0] = in_valid;
	assign side_s[0]  = in_side;
	assign base_s[0]  = in_base;
	assign rmag_s[0]  = in_rmag;
	assign tn_s[0]    = in_tn;
	assign rs_s[0]    = in_rs;
	assign rem_s[0]   = '0;
	assign q_s[0]     = '0;

	for (genvar k = 0; k < W; k++) begin : g_step
		logic [UW+1:0] acc;
		logic [UW+2:0] less1;
		logic [UW+2:0] less2;
		logic [1:0]    digit;
		logic [UW-1:0] rem_nxt;

		always_comb begin
			acc   = {1'b0, rem_s[k], 1'b0}
				+ {2'b00, (rmag_s[k][W-1-k] ? tn_s[k] : {UW{1'b0}})};
			less1 = {1'b0, acc} - {3'b000, rs_s[k]};
			less2 = {1'b0, acc} - {2'b00, rs_s[k], 1'b0};
			priority if (!less2[UW+2]) begin
				digit   = 2'd2;
				rem_nxt = less2[UW-1:0];
			end else if (!less1[UW+2]) begin
				digit   = 2'd1;
				rem_nxt = less1[UW-1:0];
			end else begin
				digit   = 2'd0;
				rem_nxt = acc[UW-1:0];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k+1] <= 1'b0;
			end else if (en) begin
				valid_s[k+1] <= valid_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_s[k+1] <= side_s[k];
				base_s[k+1] <= base_s[k];
				rmag_s[k+1] <= rmag_s[k];
				tn_s[k+1]   <= tn_s[k];
				rs_s[k+1]   <= rs_s[k];
				rem_s[k+1]  <= rem_nxt;
				q_s[k+1]    <= {q_s[k][W-2:0], 1'b0} + W'(digit);
			end
		end
	end

	always_comb begin
		offset = side_s[W].neg ? -$signed({1'b0, q_s[W]}) : $signed({1'b0, q_s[W]});
		sum    = {base_s[W][W-1], base_s[W]} + offset;
	end

	assign out_valid = valid_s[W];
	assign out_hit   = side_s[W].hit;
	assign out_point = side_s[W].hit ? sum[W-1:0] : '0;

endmodule

FILE: tb/segment_intersection_checker.sv
`timescale 1ns / 1ps
// Scoreboard for segment_intersection_unit: predicts each crossing and checks the result beats.
module segment_intersection_checker #(
	parameter int COORD_WIDTH = 16,
	localparam int IN_W  = 8 * COORD_WIDTH,
	localparam int OUT_W = ((2 * COORD_WIDTH + 7) / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	input  logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,
	input  logic             m_tvalid,
	input  logic             m_tready,
	input  logic [OUT_W-1:0] m_tdata,
	input  logic [0:0]       m_tuser,
	output int               mismatches,
	output int               pairs_pending
);

	typedef struct packed {
		logic                   hit;
		logic [COORD_WIDTH-1:0] x;
		logic [COORD_WIDTH-1:0] y;
	} crossing_t;

	crossing_t crossings_due [$];
	int bad_beats = 0;
	int results_seen = 0;

	function automatic crossing_t predict_crossing(input logic [IN_W-1:0] beat);
		logic signed [127:0] ax, ay, bx, by, cx, cy, dx, dy;
		logic signed [127:0] rx, ry, sx, sy, mx, my, rs, tn, un, px, py;
		crossing_t res;
		ax = $signed(beat[0 * COORD_WIDTH +: COORD_WIDTH]);
		ay = $signed(beat[1 * COORD_WIDTH +: COORD_WIDTH]);
		bx = $signed(beat[2 * COORD_WIDTH +: COORD_WIDTH]);
		by = $signed(beat[3 * COORD_WIDTH +: COORD_WIDTH]);
		cx = $signed(beat[4 * COORD_WIDTH +: COORD_WIDTH]);
		cy = $signed(beat[5 * COORD_WIDTH +: COORD_WIDTH]);
		dx = $signed(beat[6 * COORD_WIDTH +: COORD_WIDTH]);
		dy = $signed(beat[7 * COORD_WIDTH +: COORD_WIDTH]);
		rx = bx - ax;
		ry = by - ay;
		sx = dx - cx;
		sy = dy - cy;
		mx = cx - ax;
		my = cy - ay;
		rs = rx * sy - ry * sx;
		tn = mx * sy - my * sx;
		un = mx * ry - my * rx;
		// normalize so the denominator is not negative; t and u tests become plain range checks
		if (rs < 0) begin
			rs = -rs;
			tn = -tn;
			un = -un;
		end
		res = '0;
		if (rs != 0 && tn >= 0 && tn <= rs && un >= 0 && un <= rs) begin
			px = ax + (tn * rx) / rs;
			py = ay + (tn * ry) / rs;
			res.hit = 1'b1;
			res.x = px[COORD_WIDTH-1:0];
			res.y = py[COORD_WIDTH-1:0];
		end
		return res;
	endfunction

	always @(posedge clk) begin
		crossing_t want, got;
		if (arst_n) begin
			if (s_tvalid && s_tready)
				crossings_due.push_back(predict_crossing(s_tdata));
			if (m_tvalid && m_tready) begin
				got.hit = m_tuser[0];
				got.x = m_tdata[COORD_WIDTH-1:0];
				got.y = m_tdata[2 * COORD_WIDTH - 1:COORD_WIDTH];
				if (crossings_due.size() == 0) begin
					if (bad_beats < 10)
						$display("result beat %0d with no pair pending: hit=%0d x=%0d y=%0d",
							results_seen, got.hit, $signed(got.x), $signed(got.y));
					bad_beats++;
				end else begin
					want = crossings_due.pop_front();
					if (got !== want) begin
						if (bad_beats < 10)
							$display("result beat %0d: expected hit=%0d x=%0d y=%0d, got hit=%0d x=%0d y=%0d",
								results_seen, want.hit, $signed(want.x), $signed(want.y),
								got.hit, $signed(got.x), $signed(got.y));
						bad_beats++;
					end
				end
				results_seen++;
			end
		end
		mismatches <= bad_beats;
		pairs_pending <= crossings_due.size();
	end

endmodule

FILE: tb/segment_intersection_unit_tb.sv
`timescale 1ns / 1ps
// Testbench top for segment_intersection_unit: segment-pair stimulus, flow control and verdict.
module segment_intersection_unit_tb;

	localparam int COORD_W = 16;
	localparam int IN_W = 8 * COORD_W;
	localparam int OUT_W = ((2 * COORD_W + 7) / 8) * 8;
	localparam int LATENCY = COORD_W + 4;
	localparam int PAIRS_PER_PHASE = 460;
	localparam int CYCLE_LIMIT = 200000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;
	logic [0:0] m_tuser;
	int mismatches;
	int pairs_pending;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int run_cycles = 0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	segment_intersection_unit #(.COORD_WIDTH(COORD_W)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	segment_intersection_checker #(.COORD_WIDTH(COORD_W)) scoreboard (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.mismatches(mismatches),
		.pairs_pending(pairs_pending)
	);

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_stall_pct);
		run_cycles <= run_cycles + 1;
	end

	initial begin
		wait (run_cycles == CYCLE_LIMIT);
		$display("tb: failure");
		$finish;
	end

	function automatic int spread(input int lim);
		return int'($urandom_range(2 * lim)) - lim;
	endfunction

	task automatic send_pair(input int ax, ay, bx, by, cx, cy, dx, dy);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {dy[COORD_W-1:0], dx[COORD_W-1:0], cy[COORD_W-1:0], cx[COORD_W-1:0],
			by[COORD_W-1:0], bx[COORD_W-1:0], ay[COORD_W-1:0], ax[COORD_W-1:0]};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	task automatic send_random_pair();
		int pick, px, py, ux, uy, vx, vy, ax, ay, bx, by;
		pick = $urandom_range(99);
		if (pick < 35) begin
			send_pair($urandom(), $urandom(), $urandom(), $urandom(),
				$urandom(), $urandom(), $urandom(), $urandom());
		end else if (pick < 50) begin
			send_pair(spread(64), spread(64), spread(64), spread(64),
				spread(64), spread(64), spread(64), spread(64));
		end else if (pick < 75) begin
			// both segments centered on one point
			px = spread(8000);
			py = spread(8000);
			ux = spread(12000);
			uy = spread(12000);
			vx = spread(12000);
			vy = spread(12000);
			send_pair(px - ux, py - uy, px + ux, py + uy, px - vx, py - vy, px + vx, py + vy);
		end else if (pick < 85) begin
			// shared endpoint
			ax = spread(16000);
			ay = spread(16000);
			bx = spread(16000);
			by = spread(16000);
			if ($urandom_range(1))
				send_pair(ax, ay, bx, by, ax, ay, spread(16000), spread(16000));
			else
				send_pair(ax, ay, bx, by, bx, by, spread(16000), spread(16000));
		end else if (pick < 93) begin
			// parallel or collinear
			ax = spread(8000);
			ay = spread(8000);
			bx = spread(8000);
			by = spread(8000);
			if ($urandom_range(1)) begin
				px = bx;
				py = by;
			end else begin
				px = spread(8000);
				py = spread(8000);
			end
			if ($urandom_range(1))
				send_pair(ax, ay, bx, by, px, py, px + bx - ax, py + by - ay);
			else
				send_pair(ax, ay, bx, by, px, py, px - bx + ax, py - by + ay);
		end else begin
			// second segment starts in the middle of the first
			ax = spread(8000);
			ay = spread(8000);
			ux = spread(8000);
			uy = spread(8000);
			send_pair(ax, ay, ax + 2 * ux, ay + 2 * uy, ax + ux, ay + uy,
				ax + ux + spread(8000), ay + uy + spread(8000));
		end
	endtask

	task automatic wait_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pairs_pending != 0)
			@(posedge clk);
	endtask

	initial begin
		int idle_tab [4] = '{0, 77, 0, 13};
		int stall_tab [4] = '{0, 0, 77, 13};
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_pair(0, 0, 0, 0, 0, 0, 0, 0);
		send_pair(-100, -100, 100, 100, -100, 100, 100, -100);
		send_pair(-100, -100, 100, 100, 100, -100, -100, 100);
		send_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768);
		send_pair(32767, -32768, -32768, 32767, -32768, -32768, 32767, 32767);
		send_pair(-32768, 32767, 32767, -32768, 32767, 32767, -32768, -32768);
		send_pair(-32768, 0, 32767, 0, 0, -32768, 0, 32767);
		send_pair(0, 0, 10, 0, 10, 0, 10, 10);
		send_pair(5, 5, 20, -7, 5, 5, -3, 40);
		send_pair(0, 0, 20, 0, 10, 0, 10, 30);
		send_pair(0, 0, 10, 0, 0, 5, 10, 5);
		send_pair(0, 0, 10, 0, 5, 0, 15, 0);
		send_pair(0, 0, 10, 0, 20, 0, 30, 0);
		send_pair(0, 0, 5, 5, 20, 0, 30, -10);
		send_pair(5, 5, 5, 5, 0, 0, 10, 10);
		send_pair(0, 0, 10, 10, 3, 3, 3, 3);
		send_pair(0, 0, -10, -7, -3, 0, -3, -10);
		send_pair(0, 0, 7, 3, 2, -5, 2, 5);
		send_pair(0, 0, 10, 0, 5, 1, 5, 11);
		send_pair(21845, 21845, -21846, -21846, 21845, -21846, -21846, 21845);
		send_pair(-1, -1, -1, -1, -1, -1, -1, -1);

		for (int phase = 0; phase < 4; phase++) begin
			wait_results();
			send_idle_pct = idle_tab[phase];
			recv_stall_pct = stall_tab[phase];
			repeat (PAIRS_PER_PHASE)
				send_random_pair();
		end

		wait_results();
		repeat (3 * LATENCY) @(posedge clk);
		if (mismatches == 0 && pairs_pending == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/segi_pkg.sv
rtl/core/segi_div.sv
rtl/core/segment_intersection_unit.sv
tb/segment_intersection_checker.sv
tb/segment_intersection_unit_tb.sv
